### src/tlsf_pkg.sv
// ----------------------------------------------------------------------------
// tlsf_pkg: shared types, constants and class functions
// Header layout, list-end layout, bitmap control beats and the size-to-class
// mapping used by the allocator core and its class map.
// ----------------------------------------------------------------------------
package tlsf_pkg;

    localparam int POOL_BYTES      = 65536;
    localparam int HEADER_BYTES    = 40;
    localparam int GRANULE_BYTES   = 8;
    localparam int FIRST_LEVELS    = 32;
    localparam int MIN_SPLIT_BYTES = 64;
    localparam int CLASS_SHIFT     = 6;
    localparam int SECOND_BITS     = 3;
    localparam int SECOND_LEVELS   = 1 << SECOND_BITS;

    localparam int SLOTS     = POOL_BYTES / GRANULE_BYTES;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int GRAN_SH   = $clog2(GRANULE_BYTES);
    localparam int SIZE_W    = $clog2(POOL_BYTES);
    localparam int NEED_W    = SIZE_W + 1;
    localparam int FL_W      = $clog2(FIRST_LEVELS);
    localparam int SL_W      = SECOND_BITS;
    localparam int CLASS_W   = FL_W + SL_W;
    localparam int CLASSES   = FIRST_LEVELS * SECOND_LEVELS;
    localparam int INIT_SIZE = POOL_BYTES - HEADER_BYTES;
    localparam int SENT_SLOT = (POOL_BYTES - HEADER_BYTES) / GRANULE_BYTES;
    localparam int MIN_CLASS_BYTES = 1 << CLASS_SHIFT;

    localparam logic [2:0] STAT_OK     = 3'd0;
    localparam logic [2:0] STAT_NOFIT  = 3'd1;
    localparam logic [2:0] STAT_ZERO   = 3'd2;
    localparam logic [2:0] STAT_FREED  = 3'd3;
    localparam logic [2:0] STAT_REJECT = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] next;
        logic              has_prev;
        logic              has_next;
        logic              owned;
        logic              cfree;
        logic [SIZE_W-1:0] csize;
        logic              pfree;
        logic [SIZE_W-1:0] psize;
    } hdr_t;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } ends_t;

    typedef struct packed {
        logic            set;
        logic            clr;
        logic [FL_W-1:0] fl;
        logic [SL_W-1:0] sl;
    } map_upd_t;

    typedef struct packed {
        logic            found;
        logic [FL_W-1:0] fl;
        logic [SL_W-1:0] sl;
    } map_find_t;

    function automatic logic [FL_W-1:0] fl_of(input logic [NEED_W-1:0] size);
        logic [FL_W-1:0] msb;
        logic [FL_W-1:0] f;
        msb = '0;
        for (int i = 0; i < NEED_W; i++)
        begin
            if (size[i])
            begin
                msb = FL_W'(i);
            end
        end
        f = msb - FL_W'(CLASS_SHIFT);
        if (size < NEED_W'(MIN_CLASS_BYTES))
        begin
            f = '0;
        end
        else if (f >= FL_W'(FIRST_LEVELS - 1))
        begin
            f = FL_W'(FIRST_LEVELS - 1);
        end
        return f;
    endfunction

    function automatic logic [SL_W-1:0] sl_of(input logic [NEED_W-1:0] size,
                                              input logic [FL_W-1:0] f);
        logic [NEED_W-1:0] sh;
        sh = size >> ({1'b0, f} + (FL_W + 1)'(SECOND_BITS));
        if (size < NEED_W'(MIN_CLASS_BYTES) || f >= FL_W'(FIRST_LEVELS - 1))
        begin
            sh = '0;
        end
        return sh[SL_W-1:0];
    endfunction

    function automatic logic [CLASS_W-1:0] class_of(input logic [NEED_W-1:0] size);
        logic [FL_W-1:0] f;
        f = fl_of(size);
        return {f, sl_of(size, f)};
    endfunction

    localparam logic [FL_W-1:0] INIT_FL = fl_of(NEED_W'(INIT_SIZE));
    localparam logic [SL_W-1:0] INIT_SL = sl_of(NEED_W'(INIT_SIZE), INIT_FL);

endpackage

### src/tlsf_cmap.sv
// ----------------------------------------------------------------------------
// tlsf_cmap: first-level and second-level class bitmaps
// Holds the occupancy bitmaps, applies set and clear beats and finds the next
// non-empty class above a queried class.
// ----------------------------------------------------------------------------
module tlsf_cmap
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tlsf_pkg::map_upd_t          upd,
    input  logic [tlsf_pkg::FL_W-1:0]   qry_fl,
    input  logic [tlsf_pkg::SL_W-1:0]   qry_sl,
    output logic                        hit,
    output tlsf_pkg::map_find_t         find
);

    logic [tlsf_pkg::FIRST_LEVELS-1:0]  fl_map_reg;
    logic [tlsf_pkg::SECOND_LEVELS-1:0] sl_map_reg [tlsf_pkg::FIRST_LEVELS];
    logic [tlsf_pkg::SECOND_LEVELS-1:0] sl_cleared;
    logic [tlsf_pkg::SECOND_LEVELS-1:0] sl_above;
    logic [tlsf_pkg::FIRST_LEVELS-1:0]  fl_above;
    logic [tlsf_pkg::FL_W-1:0]          fl_pick;

    function automatic logic [tlsf_pkg::FL_W-1:0] low_fl(
        input logic [tlsf_pkg::FIRST_LEVELS-1:0] v);
        logic [tlsf_pkg::FL_W-1:0] n;
        n = '0;
        for (int i = tlsf_pkg::FIRST_LEVELS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                n = tlsf_pkg::FL_W'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [tlsf_pkg::SL_W-1:0] low_sl(
        input logic [tlsf_pkg::SECOND_LEVELS-1:0] v);
        logic [tlsf_pkg::SL_W-1:0] n;
        n = '0;
        for (int i = tlsf_pkg::SECOND_LEVELS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                n = tlsf_pkg::SL_W'(i);
            end
        end
        return n;
    endfunction

    assign hit        = sl_map_reg[qry_fl][qry_sl];
    assign sl_cleared = sl_map_reg[upd.fl] & ~(tlsf_pkg::SECOND_LEVELS'(1) << upd.sl);
    assign sl_above   = sl_map_reg[qry_fl]
                      & ({tlsf_pkg::SECOND_LEVELS{1'b1}} << ({1'b0, qry_sl} + 1'b1));
    assign fl_above   = fl_map_reg
                      & ({tlsf_pkg::FIRST_LEVELS{1'b1}} << ({1'b0, qry_fl} + 1'b1));
    assign fl_pick    = low_fl(fl_above);

    always_comb
    begin
        find.found = 1'b1;
        find.fl    = qry_fl;
        find.sl    = low_sl(sl_above);
        if (sl_above == '0)
        begin
            find.found = (fl_above != '0);
            find.fl    = fl_pick;
            find.sl    = low_sl(sl_map_reg[fl_pick]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fl_map_reg <= tlsf_pkg::FIRST_LEVELS'(1) << tlsf_pkg::INIT_FL;
            for (int i = 0; i < tlsf_pkg::FIRST_LEVELS; i++)
            begin
                sl_map_reg[i] <= '0;
            end
            sl_map_reg[tlsf_pkg::INIT_FL] <= tlsf_pkg::SECOND_LEVELS'(1) << tlsf_pkg::INIT_SL;
        end
        else if (upd.set)
        begin
            fl_map_reg[upd.fl]          <= 1'b1;
            sl_map_reg[upd.fl][upd.sl]  <= 1'b1;
        end
        else if (upd.clr)
        begin
            sl_map_reg[upd.fl] <= sl_cleared;
            if (sl_cleared == '0)
            begin
                fl_map_reg[upd.fl] <= 1'b0;
            end
        end
    end

endmodule

### src/tlsf_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// tlsf_pool_allocator_core: two-level segregated-fit pool allocator
// Allocate and free requests over a 64 KiB pool with in-memory block headers.
// ----------------------------------------------------------------------------
// After reset the block sweeps its header memory (8192 entries, one a cycle)
// and accepts no request until done. Each request is then handled one at a
// time by a sequencer around a single-port header memory and a list-end
// memory, each with a registered read: a header update that changes only
// some fields is a read followed by a write. A zero-size allocate, a free
// with a bad address and an allocate with nothing left to search finish
// soonest; a granted allocate takes longer for each block the exact-class
// walk passes over, and a free for each neighbour that merges. A result
// waits while the output holds an unaccepted beat. A finished result waits
// in the output register while the next request is taken.
module tlsf_pool_allocator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // request_bytes[15:0], block_address[31:16]
    input  logic        s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // data_address[15:0]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    localparam int SW = tlsf_pkg::SLOT_W;
    localparam int ZW = tlsf_pkg::SIZE_W;
    localparam int NW = tlsf_pkg::NEED_W;
    localparam int CW = tlsf_pkg::CLASS_W;

    localparam logic [5:0] ST_CLEAR    = 6'd0;
    localparam logic [5:0] ST_IDLE     = 6'd1;
    localparam logic [5:0] ST_A_CLASS  = 6'd2;
    localparam logic [5:0] ST_A_TAIL   = 6'd3;
    localparam logic [5:0] ST_A_WALK   = 6'd4;
    localparam logic [5:0] ST_SEARCH   = 6'd5;
    localparam logic [5:0] ST_S_TAIL   = 6'd6;
    localparam logic [5:0] ST_S_HDR    = 6'd7;
    localparam logic [5:0] ST_T_START  = 6'd8;
    localparam logic [5:0] ST_T_SPLIT  = 6'd9;
    localparam logic [5:0] ST_T_NXR    = 6'd10;
    localparam logic [5:0] ST_T_NXW    = 6'd11;
    localparam logic [5:0] ST_T_FIN    = 6'd12;
    localparam logic [5:0] ST_F_CHECK  = 6'd13;
    localparam logic [5:0] ST_F_HDR    = 6'd14;
    localparam logic [5:0] ST_F_NX     = 6'd15;
    localparam logic [5:0] ST_F_MERGED = 6'd16;
    localparam logic [5:0] ST_F_PREV   = 6'd17;
    localparam logic [5:0] ST_F_PREVH  = 6'd18;
    localparam logic [5:0] ST_F_PREVW  = 6'd19;
    localparam logic [5:0] ST_F_NXR    = 6'd20;
    localparam logic [5:0] ST_F_NXW    = 6'd21;
    localparam logic [5:0] ST_F_DONE   = 6'd22;
    localparam logic [5:0] ST_R_PREV   = 6'd23;
    localparam logic [5:0] ST_R_PREVW  = 6'd24;
    localparam logic [5:0] ST_R_HEADW  = 6'd25;
    localparam logic [5:0] ST_R_NEXT   = 6'd26;
    localparam logic [5:0] ST_R_NEXTW  = 6'd27;
    localparam logic [5:0] ST_R_TAILW  = 6'd28;
    localparam logic [5:0] ST_R_MAP    = 6'd29;
    localparam logic [5:0] ST_D_START  = 6'd30;
    localparam logic [5:0] ST_D_END    = 6'd31;
    localparam logic [5:0] ST_D_HP     = 6'd32;
    localparam logic [5:0] ST_D_HPW    = 6'd33;
    localparam logic [5:0] ST_D_SELF   = 6'd34;
    localparam logic [5:0] ST_D_SELFW  = 6'd35;
    localparam logic [5:0] ST_RESULT   = 6'd36;

    tlsf_pkg::hdr_t  hdr_mem [tlsf_pkg::SLOTS];
    tlsf_pkg::ends_t ends_mem [tlsf_pkg::CLASSES];

    logic [SW-1:0]   hdr_addr;
    logic            hdr_we;
    tlsf_pkg::hdr_t  hdr_wdata;
    tlsf_pkg::hdr_t  hdr_rdata_reg;
    logic [CW-1:0]   ends_addr;
    logic            ends_we;
    tlsf_pkg::ends_t ends_wdata;
    tlsf_pkg::ends_t ends_rdata_reg;

    logic [5:0]      state_reg, state_next;
    logic [5:0]      ret_reg, ret_next;
    logic [15:0]     req_reg, req_next;
    logic [15:0]     baddr_reg, baddr_next;
    logic [NW-1:0]   need_reg, need_next;
    logic [tlsf_pkg::FL_W-1:0] fl_reg, fl_next;
    logic [tlsf_pkg::SL_W-1:0] sl_reg, sl_next;
    logic [SW-1:0]   n_reg, n_next;
    logic [SW-1:0]   nx_reg, nx_next;
    tlsf_pkg::hdr_t  h_reg, h_next;
    tlsf_pkg::hdr_t  x_reg, x_next;
    logic [SW-1:0]   ad_slot_reg, ad_slot_next;
    logic [ZW-1:0]   ad_size_reg, ad_size_next;
    logic [SW-1:0]   old_head_reg, old_head_next;
    logic            ad_hit_reg, ad_hit_next;
    logic            split_reg, split_next;
    logic [SW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [2:0]      stat_reg, stat_next;
    logic [15:0]     res_data_reg, res_data_next;
    logic            m_valid_reg, m_valid_next;
    logic [2:0]      m_user_reg, m_user_next;
    logic [15:0]     m_data_reg, m_data_next;

    tlsf_pkg::map_upd_t  map_upd;
    tlsf_pkg::map_find_t map_find;
    logic                map_hit;
    logic [tlsf_pkg::FL_W-1:0] qry_fl;
    logic [tlsf_pkg::SL_W-1:0] qry_sl;

    logic [NW-1:0]   need_calc;
    logic [CW-1:0]   need_cls;
    logic [CW-1:0]   rm_cls;
    logic [CW-1:0]   ad_cls;
    logic [NW-1:0]   diff;
    logic [15:0]     off;
    logic            s_accept;

    tlsf_cmap u_cmap
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (map_upd),
        .qry_fl (qry_fl),
        .qry_sl (qry_sl),
        .hit    (map_hit),
        .find   (map_find)
    );

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_mem[hdr_addr] <= hdr_wdata;
        end
        hdr_rdata_reg <= hdr_mem[hdr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ends_we)
        begin
            ends_mem[ends_addr] <= ends_wdata;
        end
        ends_rdata_reg <= ends_mem[ends_addr];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tdata  = m_data_reg;

    assign need_calc = (({1'b0, req_reg} + NW'(tlsf_pkg::GRANULE_BYTES - 1))
                        & ~NW'(tlsf_pkg::GRANULE_BYTES - 1))
                     + NW'(tlsf_pkg::HEADER_BYTES);
    assign need_cls  = tlsf_pkg::class_of(need_calc);
    assign rm_cls    = tlsf_pkg::class_of({1'b0, x_reg.csize});
    assign ad_cls    = tlsf_pkg::class_of({1'b0, ad_size_reg});
    assign diff      = {1'b0, h_reg.csize} - need_reg;
    assign off       = baddr_reg - 16'(tlsf_pkg::HEADER_BYTES);

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        req_next      = req_reg;
        baddr_next    = baddr_reg;
        need_next     = need_reg;
        fl_next       = fl_reg;
        sl_next       = sl_reg;
        n_next        = n_reg;
        nx_next       = nx_reg;
        h_next        = h_reg;
        x_next        = x_reg;
        ad_slot_next  = ad_slot_reg;
        ad_size_next  = ad_size_reg;
        old_head_next = old_head_reg;
        ad_hit_next   = ad_hit_reg;
        split_next    = split_reg;
        clr_cnt_next  = clr_cnt_reg;
        stat_next     = stat_reg;
        res_data_next = res_data_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_user_next   = m_user_reg;
        m_data_next   = m_data_reg;

        hdr_addr   = n_reg;
        hdr_we     = 1'b0;
        hdr_wdata  = hdr_rdata_reg;
        ends_addr  = need_cls;
        ends_we    = 1'b0;
        ends_wdata = ends_rdata_reg;
        map_upd    = '0;
        qry_fl     = fl_reg;
        qry_sl     = sl_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                hdr_addr   = clr_cnt_reg;
                hdr_we     = 1'b1;
                hdr_wdata  = '0;
                ends_addr  = clr_cnt_reg[CW-1:0];
                ends_we    = 1'b1;
                ends_wdata = '0;
                if (clr_cnt_reg == '0)
                begin
                    hdr_wdata.csize = ZW'(tlsf_pkg::INIT_SIZE);
                    hdr_wdata.cfree = 1'b1;
                end
                else if (clr_cnt_reg == SW'(tlsf_pkg::SENT_SLOT))
                begin
                    hdr_wdata.psize = ZW'(tlsf_pkg::INIT_SIZE);
                    hdr_wdata.pfree = 1'b1;
                    hdr_wdata.csize = ZW'(tlsf_pkg::HEADER_BYTES);
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SW'(tlsf_pkg::SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    req_next   = s_axis_tdata[15:0];
                    baddr_next = s_axis_tdata[31:16];
                    state_next = (s_axis_tuser == tlsf_pkg::CMD_FREE) ? ST_F_CHECK
                                                                       : ST_A_CLASS;
                end
            end
            ST_A_CLASS:
            begin
                need_next = need_calc;
                fl_next   = need_cls[CW-1:tlsf_pkg::SL_W];
                sl_next   = need_cls[tlsf_pkg::SL_W-1:0];
                qry_fl    = need_cls[CW-1:tlsf_pkg::SL_W];
                qry_sl    = need_cls[tlsf_pkg::SL_W-1:0];
                ends_addr = need_cls;
                if (req_reg == '0)
                begin
                    stat_next     = tlsf_pkg::STAT_ZERO;
                    res_data_next = '0;
                    state_next    = ST_RESULT;
                end
                else if (map_hit)
                begin
                    state_next = ST_A_TAIL;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_A_TAIL:
            begin
                n_next     = ends_rdata_reg.tail;
                hdr_addr   = ends_rdata_reg.tail;
                state_next = ST_A_WALK;
            end
            ST_A_WALK:
            begin
                h_next = hdr_rdata_reg;
                if ({1'b0, hdr_rdata_reg.csize} >= need_reg)
                begin
                    state_next = ST_T_START;
                end
                else if (!hdr_rdata_reg.has_prev)
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    n_next   = hdr_rdata_reg.prev;
                    hdr_addr = hdr_rdata_reg.prev;
                end
            end
            ST_SEARCH:
            begin
                ends_addr = {map_find.fl, map_find.sl};
                if (!map_find.found)
                begin
                    stat_next     = tlsf_pkg::STAT_NOFIT;
                    res_data_next = '0;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    state_next = ST_S_TAIL;
                end
            end
            ST_S_TAIL:
            begin
                n_next     = ends_rdata_reg.tail;
                hdr_addr   = ends_rdata_reg.tail;
                state_next = ST_S_HDR;
            end
            ST_S_HDR:
            begin
                h_next     = hdr_rdata_reg;
                state_next = ST_T_START;
            end
            ST_T_START:
            begin
                x_next     = h_reg;
                ret_next   = ST_T_SPLIT;
                state_next = ST_R_PREV;
            end
            ST_T_SPLIT:
            begin
                nx_next    = n_reg + SW'(h_reg.csize >> tlsf_pkg::GRAN_SH);
                split_next = ({1'b0, h_reg.csize} >= need_reg)
                          && (diff >= NW'(tlsf_pkg::MIN_SPLIT_BYTES));
                ad_slot_next = n_reg + SW'(need_reg >> tlsf_pkg::GRAN_SH);
                ad_size_next = diff[ZW-1:0];
                hdr_addr   = n_reg + SW'(need_reg >> tlsf_pkg::GRAN_SH);
                hdr_wdata  = '0;
                hdr_wdata.psize = need_reg[ZW-1:0];
                hdr_wdata.csize = diff[ZW-1:0];
                hdr_wdata.cfree = 1'b1;
                hdr_we     = split_next;
                state_next = ST_T_NXR;
            end
            ST_T_NXR:
            begin
                hdr_addr   = nx_reg;
                state_next = ST_T_NXW;
            end
            ST_T_NXW:
            begin
                hdr_addr  = nx_reg;
                hdr_we    = 1'b1;
                hdr_wdata.psize = split_reg ? ad_size_reg : h_reg.csize;
                hdr_wdata.pfree = split_reg;
                ret_next  = ST_T_FIN;
                state_next = split_reg ? ST_D_START : ST_T_FIN;
            end
            ST_T_FIN:
            begin
                hdr_addr  = n_reg;
                hdr_we    = 1'b1;
                hdr_wdata = h_reg;
                hdr_wdata.csize    = split_reg ? need_reg[ZW-1:0] : h_reg.csize;
                hdr_wdata.cfree    = 1'b0;
                hdr_wdata.owned    = 1'b1;
                hdr_wdata.prev     = '0;
                hdr_wdata.next     = '0;
                hdr_wdata.has_prev = 1'b0;
                hdr_wdata.has_next = 1'b0;
                stat_next     = tlsf_pkg::STAT_OK;
                res_data_next = 16'((ZW'(n_reg) << tlsf_pkg::GRAN_SH)
                                    + ZW'(tlsf_pkg::HEADER_BYTES));
                state_next    = ST_RESULT;
            end
            ST_F_CHECK:
            begin
                n_next   = SW'(off >> tlsf_pkg::GRAN_SH);
                hdr_addr = SW'(off >> tlsf_pkg::GRAN_SH);
                if (baddr_reg < 16'(tlsf_pkg::HEADER_BYTES)
                    || off[tlsf_pkg::GRAN_SH-1:0] != '0)
                begin
                    stat_next     = tlsf_pkg::STAT_REJECT;
                    res_data_next = '0;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    state_next = ST_F_HDR;
                end
            end
            ST_F_HDR:
            begin
                h_next       = hdr_rdata_reg;
                h_next.owned = 1'b0;
                nx_next      = n_reg + SW'(hdr_rdata_reg.csize >> tlsf_pkg::GRAN_SH);
                hdr_addr     = n_reg + SW'(hdr_rdata_reg.csize >> tlsf_pkg::GRAN_SH);
                if (!hdr_rdata_reg.owned)
                begin
                    stat_next     = tlsf_pkg::STAT_REJECT;
                    res_data_next = '0;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    state_next = ST_F_NX;
                end
            end
            ST_F_NX:
            begin
                state_next = ST_F_MERGED;
                if (hdr_rdata_reg.cfree)
                begin
                    x_next       = hdr_rdata_reg;
                    h_next.csize = h_reg.csize + hdr_rdata_reg.csize;
                    ret_next     = ST_F_MERGED;
                    state_next   = ST_R_PREV;
                end
            end
            ST_F_MERGED:
            begin
                nx_next      = n_reg + SW'(h_reg.csize >> tlsf_pkg::GRAN_SH);
                h_next.cfree = 1'b1;
                hdr_addr     = n_reg;
                hdr_we       = 1'b1;
                hdr_wdata    = h_reg;
                hdr_wdata.cfree = 1'b1;
                ad_slot_next = n_reg;
                ad_size_next = h_reg.csize;
                state_next   = ST_F_PREV;
            end
            ST_F_PREV:
            begin
                hdr_addr = n_reg - SW'(h_reg.psize >> tlsf_pkg::GRAN_SH);
                if (h_reg.pfree)
                begin
                    ad_slot_next = n_reg - SW'(h_reg.psize >> tlsf_pkg::GRAN_SH);
                    state_next   = ST_F_PREVH;
                end
                else
                begin
                    state_next = ST_F_NXR;
                end
            end
            ST_F_PREVH:
            begin
                x_next     = hdr_rdata_reg;
                ret_next   = ST_F_PREVW;
                state_next = ST_R_PREV;
            end
            ST_F_PREVW:
            begin
                hdr_addr  = ad_slot_reg;
                hdr_we    = 1'b1;
                hdr_wdata = x_reg;
                hdr_wdata.csize    = x_reg.csize + h_reg.csize;
                hdr_wdata.prev     = '0;
                hdr_wdata.next     = '0;
                hdr_wdata.has_prev = 1'b0;
                hdr_wdata.has_next = 1'b0;
                ad_size_next = x_reg.csize + h_reg.csize;
                state_next   = ST_F_NXR;
            end
            ST_F_NXR:
            begin
                hdr_addr   = nx_reg;
                state_next = ST_F_NXW;
            end
            ST_F_NXW:
            begin
                hdr_addr  = nx_reg;
                hdr_we    = 1'b1;
                hdr_wdata.psize = ad_size_reg;
                hdr_wdata.pfree = 1'b1;
                ret_next   = ST_F_DONE;
                state_next = ST_D_START;
            end
            ST_F_DONE:
            begin
                stat_next     = tlsf_pkg::STAT_FREED;
                res_data_next = '0;
                state_next    = ST_RESULT;
            end
            ST_R_PREV:
            begin
                hdr_addr   = x_reg.prev;
                ends_addr  = rm_cls;
                state_next = x_reg.has_prev ? ST_R_PREVW : ST_R_HEADW;
            end
            ST_R_PREVW:
            begin
                hdr_addr  = x_reg.prev;
                hdr_we    = 1'b1;
                hdr_wdata.next     = x_reg.next;
                hdr_wdata.has_next = x_reg.has_next;
                state_next = ST_R_NEXT;
            end
            ST_R_HEADW:
            begin
                ends_addr  = rm_cls;
                ends_we    = 1'b1;
                ends_wdata.head = x_reg.next;
                state_next = ST_R_NEXT;
            end
            ST_R_NEXT:
            begin
                hdr_addr   = x_reg.next;
                ends_addr  = rm_cls;
                state_next = x_reg.has_next ? ST_R_NEXTW : ST_R_TAILW;
            end
            ST_R_NEXTW:
            begin
                hdr_addr  = x_reg.next;
                hdr_we    = 1'b1;
                hdr_wdata.prev     = x_reg.prev;
                hdr_wdata.has_prev = x_reg.has_prev;
                state_next = ST_R_MAP;
            end
            ST_R_TAILW:
            begin
                ends_addr  = rm_cls;
                ends_we    = 1'b1;
                ends_wdata.tail = x_reg.prev;
                state_next = ST_R_MAP;
            end
            ST_R_MAP:
            begin
                map_upd.clr = !x_reg.has_prev && !x_reg.has_next;
                map_upd.fl  = rm_cls[CW-1:tlsf_pkg::SL_W];
                map_upd.sl  = rm_cls[tlsf_pkg::SL_W-1:0];
                state_next  = ret_reg;
            end
            ST_D_START:
            begin
                qry_fl      = ad_cls[CW-1:tlsf_pkg::SL_W];
                qry_sl      = ad_cls[tlsf_pkg::SL_W-1:0];
                ad_hit_next = map_hit;
                ends_addr   = ad_cls;
                state_next  = ST_D_END;
            end
            ST_D_END:
            begin
                ends_addr  = ad_cls;
                ends_we    = 1'b1;
                ends_wdata.head = ad_slot_reg;
                ends_wdata.tail = ad_hit_reg ? ends_rdata_reg.tail : ad_slot_reg;
                old_head_next   = ends_rdata_reg.head;
                map_upd.set = 1'b1;
                map_upd.fl  = ad_cls[CW-1:tlsf_pkg::SL_W];
                map_upd.sl  = ad_cls[tlsf_pkg::SL_W-1:0];
                state_next  = ad_hit_reg ? ST_D_HP : ST_D_SELF;
            end
            ST_D_HP:
            begin
                hdr_addr   = old_head_reg;
                state_next = ST_D_HPW;
            end
            ST_D_HPW:
            begin
                hdr_addr  = old_head_reg;
                hdr_we    = 1'b1;
                hdr_wdata.prev     = ad_slot_reg;
                hdr_wdata.has_prev = 1'b1;
                state_next = ST_D_SELF;
            end
            ST_D_SELF:
            begin
                hdr_addr   = ad_slot_reg;
                state_next = ST_D_SELFW;
            end
            ST_D_SELFW:
            begin
                hdr_addr  = ad_slot_reg;
                hdr_we    = 1'b1;
                hdr_wdata.has_prev = 1'b0;
                hdr_wdata.next     = old_head_reg;
                hdr_wdata.has_next = ad_hit_reg;
                state_next = ret_reg;
            end
            ST_RESULT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = stat_reg;
                    m_data_next  = res_data_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            ret_reg     <= ST_IDLE;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        baddr_reg    <= baddr_next;
        need_reg     <= need_next;
        fl_reg       <= fl_next;
        sl_reg       <= sl_next;
        n_reg        <= n_next;
        nx_reg       <= nx_next;
        h_reg        <= h_next;
        x_reg        <= x_next;
        ad_slot_reg  <= ad_slot_next;
        ad_size_reg  <= ad_size_next;
        old_head_reg <= old_head_next;
        ad_hit_reg   <= ad_hit_next;
        split_reg    <= split_next;
        stat_reg     <= stat_next;
        res_data_reg <= res_data_next;
        m_user_reg   <= m_user_next;
        m_data_reg   <= m_data_next;
    end

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !hdr_we && !ends_we)
        else $error("memory written while idle");

    a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != tlsf_pkg::STAT_OK |-> m_axis_tdata == '0)
        else $error("nonzero address on a failed beat");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> state_reg != ST_IDLE)
        else $error("request accepted without leaving idle");

endmodule
